/* design/mlfq_pkg.sv */
// Shared types and constants for the multilevel feedback scheduler.
// No dependencies; imported by mlfq_ctrl and the top level.
`timescale 1ns / 1ps

package mlfq_pkg;

    localparam int PID_W    = 8;
    localparam int TIME_W   = 16;
    localparam int LVL_W    = 3;     // width of the from_level result field
    localparam int BOT_W    = 3;     // width of the bottom_level register
    localparam int REC_W    = PID_W + 2 * TIME_W;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int IN_DW    = PID_W + 3 * TIME_W;                 // 56
    localparam int OUT_RAW  = 1 + PID_W + 2 * TIME_W + LVL_W + 3; // 47
    localparam int OUT_DW   = ((OUT_RAW + 7) / 8) * 8;            // 48

    localparam logic [ADDR_W-1:0] REG_BOTTOM_ADDR = 3'd0;
    localparam logic [BOT_W-1:0]  BOTTOM_RST      = 3'd3;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_REQUEUE = 2'd1,
        ACT_SELECT  = 2'd2,
        ACT_CHECK   = 2'd3
    } t_action;

    typedef struct packed {
        logic [TIME_W-1:0] done_time;
        logic [TIME_W-1:0] service_time;
        logic [PID_W-1:0]  proc_id;
    } t_rec;

    // Per-request status from the queue controller
    typedef struct packed {
        logic             found;
        logic [LVL_W-1:0] level;
        logic             keep_running;
        logic             none_waiting;
        logic             overflow;
    } t_step_res;

endpackage

/* design/multilevel_feedback_scheduler.sv */
// Multilevel feedback ready-queue scheduler, one FIFO per level in a shared RAM.
// A request waits in the request register, then moves on to the result register, its record
// read into the RAM read register, when the result slot is empty or draining; throughput one
// request per cycle while results are taken, set by the mlfq_ctrl pointer update and RAM read.
// A held result blocks input only once the request register is also occupied. Reset
// (sync, active low) clears pointers, counts, last level and bottom_level (to 3), not the RAM.
`timescale 1ns / 1ps

module multilevel_feedback_scheduler #(
    parameter int MAX_LEVELS  = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // proc_id[7:0], service_time[23:8], done_time[39:24], elapsed_time[55:40]
    input  logic [mlfq_pkg::IN_DW-1:0]    i_s_tdata,
    // action[1:0]
    input  logic [1:0]                    i_s_tuser,
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // found[0], out_proc_id[8:1], out_service_time[24:9], out_done_time[40:25],
    // from_level[43:41], keep_running[44], none_waiting[45], overflow[46], zero[47]
    output logic [mlfq_pkg::OUT_DW-1:0]   o_m_tdata,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mlfq_pkg::ADDR_W-1:0]   paddr,
    input  logic [mlfq_pkg::DATA_W-1:0]   pwdata,
    output logic [mlfq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    import mlfq_pkg::*;

    localparam int LW = $clog2(MAX_LEVELS);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int AW = LW + PW;
    localparam int RAM_DEPTH = MAX_LEVELS * (2 ** PW);

    // config register
    logic [BOT_W-1:0] r_bottom;

    // stage 1: request register (doubles as skid while the result waits)
    logic              r_s1_valid;
    logic [IN_DW-1:0]  r_s1_data;
    t_action           r_s1_action;
    logic              s1_adv;
    logic              in_acc;

    // stage 2: result register, record comes from the RAM read register
    logic              r_s2_valid;
    t_step_res         r_s2_res;

    t_rec              s1_rec;
    t_rec              rd_rec;
    t_step_res         step_res;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [REC_W-1:0]  ram_wdata;
    logic [REC_W-1:0]  ram_rdata;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == REG_BOTTOM_ADDR) ? DATA_W'(r_bottom) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom <= BOTTOM_RST;
        end else if (psel && penable && pwrite && pready && (paddr == REG_BOTTOM_ADDR)) begin
            r_bottom <= pwdata[BOT_W-1:0];
        end
    end

    // ---------------- handshake / pipeline ----------------
    // Stage 1 moves on when the result slot is empty or being drained.
    assign s1_adv     = r_s1_valid && (!r_s2_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign in_acc     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_data   <= i_s_tdata;
            r_s1_action <= t_action'(i_s_tuser);
        end
        if (s1_adv) begin
            r_s2_res <= step_res;
        end
    end

    assign s1_rec.proc_id      = r_s1_data[PID_W-1:0];
    assign s1_rec.service_time = r_s1_data[PID_W +: TIME_W];
    assign s1_rec.done_time    = r_s1_data[PID_W + TIME_W +: TIME_W];

    // ---------------- queue control and record store ----------------
    mlfq_ctrl #(
        .MAX_LEVELS  (MAX_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (s1_adv),
        .i_action  (r_s1_action),
        .i_rec     (s1_rec),
        .i_elapsed (r_s1_data[PID_W + 2*TIME_W +: TIME_W]),
        .i_bottom  (r_bottom),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata),
        .o_re      (ram_re),
        .o_raddr   (ram_raddr),
        .o_res     (step_res)
    );

    mlfq_ram #(
        .WIDTH (REC_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // RAM read register holds while the result waits (read only on advance)
    assign rd_rec = ram_rdata;

    // ---------------- result ----------------
    assign o_m_tvalid = r_s2_valid;
    assign o_m_tdata  = {
        1'b0,
        r_s2_res.overflow,
        r_s2_res.none_waiting,
        r_s2_res.keep_running,
        r_s2_res.level,
        r_s2_res.found ? rd_rec.done_time    : {TIME_W{1'b0}},
        r_s2_res.found ? rd_rec.service_time : {TIME_W{1'b0}},
        r_s2_res.found ? rd_rec.proc_id      : {PID_W{1'b0}},
        r_s2_res.found
    };

endmodule

/* design/mlfq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mlfq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/mlfq_ctrl.sv */
// Queue control: per-level head/tail/count, level select, requeue and check logic.
// Depends on mlfq_pkg; drives the record RAM ports.
`timescale 1ns / 1ps

module mlfq_ctrl #(
    parameter int MAX_LEVELS  = 8,
    parameter int QUEUE_DEPTH = 16,
    localparam int LW = $clog2(MAX_LEVELS),
    localparam int PW = $clog2(QUEUE_DEPTH),
    localparam int AW = LW + PW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  mlfq_pkg::t_action             i_action,
    input  mlfq_pkg::t_rec                i_rec,
    input  logic [mlfq_pkg::TIME_W-1:0]   i_elapsed,
    input  logic [mlfq_pkg::BOT_W-1:0]    i_bottom,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [mlfq_pkg::REC_W-1:0]    o_wdata,
    output logic                          o_re,
    output logic [AW-1:0]                 o_raddr,
    output mlfq_pkg::t_step_res           o_res
);

    import mlfq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [PW-1:0] r_head [MAX_LEVELS];
    logic [PW-1:0] r_tail [MAX_LEVELS];
    logic [CW-1:0] r_cnt  [MAX_LEVELS];
    logic [LW-1:0] r_cur;
    logic          r_known;

    logic [PW-1:0] n_head [MAX_LEVELS];
    logic [PW-1:0] n_tail [MAX_LEVELS];
    logic [CW-1:0] n_cnt  [MAX_LEVELS];
    logic [LW-1:0] n_cur;
    logic          n_known;

    logic [MAX_LEVELS-1:0] nonempty;
    logic [MAX_LEVELS-1:0] full;
    logic                  sel_hit;
    logic [LW-1:0]         sel_lvl;
    logic [LW-1:0]         eb;
    logic [LW:0]           rq_lvl;
    logic                  rq_sat;
    logic [LW-1:0]         push_lvl;
    logic                  push_req;
    logic                  push_ok;
    logic                  pop;
    logic [LW-1:0]         chk_lvl;
    logic                  finished;
    logic                  in_quantum;
    logic                  all_empty;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        for (int l = 0; l < MAX_LEVELS; l++) begin
            nonempty[l] = (r_cnt[l] != '0);
            full[l]     = (r_cnt[l] == CW'(QUEUE_DEPTH));
        end

        // highest-priority non-empty level
        sel_hit = 1'b0;
        sel_lvl = '0;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            if (!sel_hit && nonempty[l]) begin
                sel_hit = 1'b1;
                sel_lvl = LW'(l);
            end
        end

        // bottom level clamped to the levels that exist
        if (32'(i_bottom) > 32'(MAX_LEVELS - 1)) begin
            eb = LW'(MAX_LEVELS - 1);
        end else begin
            eb = LW'(i_bottom);
        end

        rq_lvl = r_known ? ({1'b0, r_cur} + 1'b1) : '0;
        rq_sat = (rq_lvl > {1'b0, eb});
        if (i_action == ACT_INSERT) begin
            push_lvl = '0;
        end else if (rq_sat) begin
            push_lvl = eb;
        end else begin
            push_lvl = rq_lvl[LW-1:0];
        end

        push_req = (i_action == ACT_INSERT) || (i_action == ACT_REQUEUE);
        push_ok  = push_req && !full[push_lvl];
        pop      = (i_action == ACT_SELECT) && sel_hit;

        // check: finished test at full width, quantum 2^level above bottom
        chk_lvl    = r_known ? r_cur : '0;
        finished   = ({1'b0, i_rec.done_time} + {1'b0, i_elapsed})
                     >= {1'b0, i_rec.service_time};
        in_quantum = (chk_lvl >= eb) || ((i_elapsed >> chk_lvl) == '0);

        n_cur   = pop ? sel_lvl : r_cur;
        n_known = pop ? 1'b1 : r_known;
        all_empty = 1'b1;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            n_head[l] = r_head[l];
            n_tail[l] = r_tail[l];
            n_cnt[l]  = r_cnt[l];
            if (push_ok && (push_lvl == LW'(l))) begin
                n_tail[l] = f_next(r_tail[l]);
                n_cnt[l]  = r_cnt[l] + 1'b1;
            end
            if (pop && (sel_lvl == LW'(l))) begin
                n_head[l] = f_next(r_head[l]);
                n_cnt[l]  = r_cnt[l] - 1'b1;
            end
            if (n_cnt[l] != '0) begin
                all_empty = 1'b0;
            end
        end

        o_res.found        = pop;
        o_res.level        = pop ? LVL_W'(sel_lvl) : '0;
        o_res.keep_running = (i_action == ACT_CHECK) && !finished && in_quantum;
        o_res.none_waiting = all_empty;
        o_res.overflow     = (push_req && !push_ok)
                             || ((i_action == ACT_REQUEUE) && rq_sat);
    end

    assign o_we    = i_step && push_ok;
    assign o_waddr = {push_lvl, r_tail[push_lvl]};
    assign o_wdata = i_rec;
    assign o_re    = i_step && pop;
    assign o_raddr = {sel_lvl, r_head[sel_lvl]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_cnt[l]  <= '0;
            end
            r_cur   <= '0;
            r_known <= 1'b0;
        end else if (i_step) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                r_head[l] <= n_head[l];
                r_tail[l] <= n_tail[l];
                r_cnt[l]  <= n_cnt[l];
            end
            r_cur   <= n_cur;
            r_known <= n_known;
        end
    end

endmodule

/* tb/multilevel_feedback_scheduler_tb.sv */
// Self-checking testbench for multilevel_feedback_scheduler: a directed table, then random
// scheduler traffic, checked against a behavioral queue model in this file or hand-written results.
// Depends on mlfq_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module multilevel_feedback_scheduler_tb;
    import mlfq_pkg::*;

    localparam int MAX_LEVELS  = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 272;
    localparam int HOLD_CYCLES = 100;   // long receiver hold-off, fills the pipeline
    localparam int STALL_LIMIT = 2000;  // cycles with no handshake or register access before giving up
    localparam int TAIL_CYCLES = 6;     // settle time after the last result

    // bottom_level per random phase; index 0 first. The top value, 7, is in here, 0 is not.
    localparam logic [PHASES-1:0][BOT_W-1:0] PHASE_BOTTOM =
        {3'd4, 3'd6, 3'd2, 3'd5, 3'd1, 3'd7};

    // Result fields, MSB first, so the struct maps straight onto o_m_tdata[46:0]
    typedef struct packed {
        logic              overflow;
        logic              none_waiting;
        logic              keep_running;
        logic [LVL_W-1:0]  from_level;
        logic [TIME_W-1:0] done_time;
        logic [TIME_W-1:0] service_time;
        logic [PID_W-1:0]  proc_id;
        logic              found;
    } t_sched_result;

    typedef struct {
        t_action           act;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] svc;
        logic [TIME_W-1:0] dn;
        logic [TIME_W-1:0] el;
        bit                typed;   // 1: use the hand-written result below
        t_sched_result     want;
    } t_stim_row;

    // Hand-written results, fields MSB first (see t_sched_result)
    localparam t_sched_result RES_EMPTY  = '{1'b0, 1'b1, 1'b0, 3'd0, 16'h0, 16'h0, 8'h0, 1'b0};
    localparam t_sched_result RES_KEEP   = '{1'b0, 1'b1, 1'b1, 3'd0, 16'h0, 16'h0, 8'h0, 1'b0};
    localparam t_sched_result RES_QUEUED = '0;
    localparam t_sched_result RES_TOP    =
        '{1'b0, 1'b0, 1'b0, 3'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1};
    localparam t_sched_result RES_LAST   =
        '{1'b0, 1'b1, 1'b0, 3'd0, 16'h0000, 16'h0000, 8'h00, 1'b1};

    // Directed walk with bottom_level at its reset value of 3. The first rows have
    // results readable by eye; the rest go through the scheduler model.
    t_stim_row directed_rows [25] = '{
        // select on empty queues right after reset
        '{ACT_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, RES_EMPTY},
        // checks before any select run with the level-0 quantum of one tick
        '{ACT_CHECK,   8'h00, 16'h0005, 16'h0000, 16'h0000, 1'b1, RES_KEEP},
        '{ACT_CHECK,   8'h00, 16'h0005, 16'h0000, 16'h0001, 1'b1, RES_EMPTY},
        // finish test must not wrap at 16 bits
        '{ACT_CHECK,   8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, RES_EMPTY},
        // requeue before any select lands in level 0
        '{ACT_REQUEUE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, RES_QUEUED},
        '{ACT_INSERT,  8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, RES_QUEUED},
        '{ACT_SELECT,  8'h3C, 16'h1234, 16'h5678, 16'h9ABC, 1'b1, RES_TOP},
        '{ACT_SELECT,  8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, RES_LAST},
        '{ACT_SELECT,  8'hC3, 16'hEDCB, 16'hA987, 16'h6543, 1'b1, RES_EMPTY},
        // walk one process down to the bottom level
        '{ACT_INSERT,  8'h5A, 16'd100,  16'd10,   16'd0,    1'b0, '0},
        '{ACT_REQUEUE, 8'hA5, 16'd200,  16'd0,    16'd0,    1'b0, '0},
        '{ACT_SELECT,  8'h00, 16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ACT_CHECK,   8'h5A, 16'd100,  16'd10,   16'd0,    1'b0, '0},
        '{ACT_REQUEUE, 8'h5A, 16'd100,  16'd11,   16'd0,    1'b0, '0},
        '{ACT_SELECT,  8'h00, 16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ACT_CHECK,   8'hA5, 16'd200,  16'd0,    16'd1,    1'b0, '0},
        '{ACT_CHECK,   8'hA5, 16'd200,  16'd0,    16'd2,    1'b0, '0},
        '{ACT_REQUEUE, 8'hA5, 16'd200,  16'd2,    16'd0,    1'b0, '0},
        '{ACT_SELECT,  8'h00, 16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ACT_SELECT,  8'h00, 16'd0,    16'd0,    16'd0,    1'b0, '0},
        '{ACT_REQUEUE, 8'hA5, 16'd200,  16'd5,    16'd0,    1'b0, '0},
        '{ACT_SELECT,  8'h00, 16'd0,    16'd0,    16'd0,    1'b0, '0},
        // bottom level has no quantum, only the finish test
        '{ACT_CHECK,   8'hA5, 16'd200,  16'd5,    16'd150,  1'b0, '0},
        // requeue below the bottom saturates and flags
        '{ACT_REQUEUE, 8'hA5, 16'd200,  16'd155,  16'd0,    1'b0, '0},
        '{ACT_SELECT,  8'h00, 16'd0,    16'd0,    16'd0,    1'b0, '0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [IN_DW-1:0]    i_s_tdata;   // proc_id, service_time, done_time, elapsed_time
    logic [1:0]          i_s_tuser;   // action
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OUT_DW-1:0]   o_m_tdata;   // found, proc_id, service, done, level, keep, none, ovf
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Scheduler model state
    t_rec             level_fifo [MAX_LEVELS][$];
    logic [LVL_W-1:0] last_level    = '0;
    bit               level_seen    = 1'b0;
    logic [BOT_W-1:0] bottom_shadow = BOTTOM_RST;

    t_sched_result    expected_sched_results [$];
    int               mismatches    = 0;
    int               requests_sent = 0;

    // Handshake between the request driver and the checker / ready process
    bit               typed_pending = 1'b0;
    t_sched_result    typed_want    = '0;
    bit               sel_found     = 1'b0;
    t_rec             sel_rec       = '0;
    logic [LVL_W-1:0] sel_level     = '0;
    bit               no_idle       = 1'b0;
    bit               hold_off_req  = 1'b0;

    multilevel_feedback_scheduler #(
        .MAX_LEVELS  (MAX_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Scheduler model
    // ------------------------------------------------------------------

    function automatic bit enqueue_record(input int lvl, input t_rec rec);
        if (level_fifo[lvl].size() >= QUEUE_DEPTH)
            return 1'b0;
        level_fifo[lvl].push_back(rec);
        return 1'b1;
    endfunction

    // Applies one request to the model state and returns its result
    function automatic t_sched_result predict_schedule(input t_action act, input t_rec rec,
                                                       input logic [TIME_W-1:0] elapsed);
        t_sched_result res;
        t_rec          head;
        logic [3:0]    target;
        logic [TIME_W:0] progress;
        int            l;
        int            waiting;

        res = '0;
        case (act)
            ACT_INSERT: begin
                if (!enqueue_record(0, rec))
                    res.overflow = 1'b1;
            end
            ACT_REQUEUE: begin
                // one level below the last selected one; level 0 if nothing selected yet
                target = level_seen ? {1'b0, last_level} + 4'd1 : 4'd0;
                if (target > {1'b0, bottom_shadow}) begin
                    target       = {1'b0, bottom_shadow};
                    res.overflow = 1'b1;
                end
                if (!enqueue_record(int'(target), rec))
                    res.overflow = 1'b1;
            end
            ACT_SELECT: begin
                // all levels are scanned, even those below a lowered bottom
                for (l = 0; l < MAX_LEVELS; l++) begin
                    if (!res.found && level_fifo[l].size() != 0) begin
                        head             = level_fifo[l].pop_front();
                        res.found        = 1'b1;
                        res.proc_id      = head.proc_id;
                        res.service_time = head.service_time;
                        res.done_time    = head.done_time;
                        res.from_level   = LVL_W'(l);
                        last_level       = LVL_W'(l);
                        level_seen       = 1'b1;
                    end
                end
            end
            default: begin
                target   = level_seen ? {1'b0, last_level} : 4'd0;
                progress = {1'b0, rec.done_time} + {1'b0, elapsed};
                if (progress >= {1'b0, rec.service_time})
                    res.keep_running = 1'b0;
                else if (target >= {1'b0, bottom_shadow})
                    res.keep_running = 1'b1;
                else
                    res.keep_running = (int'(elapsed) < (1 << target));
            end
        endcase

        waiting = 0;
        for (l = 0; l < MAX_LEVELS; l++)
            waiting += level_fifo[l].size();
        res.none_waiting = (waiting == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_field(input string name, input logic [TIME_W-1:0] want,
                                input logic [TIME_W-1:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
    endtask

    task automatic compare_result(input t_sched_result want, input t_sched_result got);
        if (got.found !== want.found)
            report_field("found", TIME_W'(want.found), TIME_W'(got.found));
        if (got.proc_id !== want.proc_id)
            report_field("out_proc_id", TIME_W'(want.proc_id), TIME_W'(got.proc_id));
        if (got.service_time !== want.service_time)
            report_field("out_service_time", want.service_time, got.service_time);
        if (got.done_time !== want.done_time)
            report_field("out_done_time", want.done_time, got.done_time);
        if (got.from_level !== want.from_level)
            report_field("from_level", TIME_W'(want.from_level), TIME_W'(got.from_level));
        if (got.keep_running !== want.keep_running)
            report_field("keep_running", TIME_W'(want.keep_running),
                         TIME_W'(got.keep_running));
        if (got.none_waiting !== want.none_waiting)
            report_field("none_waiting", TIME_W'(want.none_waiting),
                         TIME_W'(got.none_waiting));
        if (got.overflow !== want.overflow)
            report_field("overflow", TIME_W'(want.overflow), TIME_W'(got.overflow));
    endtask

    // Results are checked before the request of the same edge is predicted, so
    // the order within the time step never matters.
    always @(posedge i_clk) begin : request_result_monitor
        t_sched_result predicted;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_sched_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         o_m_tdata);
                mismatches++;
            end else begin
                compare_result(expected_sched_results.pop_front(),
                               t_sched_result'(o_m_tdata[OUT_RAW-1:0]));
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            predicted = predict_schedule(t_action'(i_s_tuser), t_rec'(i_s_tdata[REC_W-1:0]),
                                         i_s_tdata[IN_DW-1:REC_W]);
            if (t_action'(i_s_tuser) == ACT_SELECT) begin
                // the request driver runs the popped process next
                sel_found = predicted.found;
                sel_rec   = '{predicted.done_time, predicted.service_time, predicted.proc_id};
                sel_level = predicted.from_level;
            end
            expected_sched_results.push_back(typed_pending ? typed_want : predicted);
        end
    end

    // ------------------------------------------------------------------
    // Result side backpressure: random stall bursts, one long hold-off on
    // request, and none at all once no_idle is set.
    // ------------------------------------------------------------------
    initial begin : result_ready
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_tready   = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // Ends the run when neither stream nor the register port moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("multilevel_feedback_scheduler_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver. Called and returns at a falling edge; valid stays high
    // from one request to the next unless a gap is inserted.
    // ------------------------------------------------------------------
    task automatic send_request(input t_action act, input t_rec rec,
                                input logic [TIME_W-1:0] elapsed,
                                input bit typed, input t_sched_result want);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_s_tvalid    = 1'b1;
        i_s_tuser     = act;
        i_s_tdata     = {elapsed, rec};
        typed_pending = typed;
        typed_want    = want;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
    endtask

    // Waits out every outstanding result plus the pipeline latency
    task automatic wait_drained();
        while (expected_sched_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic check_bottom_level(input logic [BOT_W-1:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = REG_BOTTOM_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== DATA_W'(want)) begin
            $display("%0t: bottom_level readback mismatch, expected %0h, actual %0h",
                     $time, want, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Only called with both streams idle
    task automatic write_bottom_level(input logic [BOT_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_BOTTOM_ADDR;
        pwdata  = DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        bottom_shadow = value;
        @(negedge i_clk);
        check_bottom_level(value);
    endtask

    // Mostly short jobs so processes finish within a few quanta; some full range
    function automatic t_rec random_process(input bit full_range);
        t_rec rec;
        rec.proc_id      = PID_W'($urandom);
        rec.service_time = full_range ? TIME_W'($urandom) : TIME_W'($urandom_range(1, 120));
        rec.done_time    = full_range ? TIME_W'($urandom) : TIME_W'($urandom_range(0, 20));
        return rec;
    endfunction

    // One scheduling round: select, run with a few checks, then preempt
    // (requeue with the time used so far) unless it finished or left.
    task automatic run_one_process();
        t_rec            rec;
        int              quantum;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W:0] progress;

        send_request(ACT_SELECT, random_process(1'b1), TIME_W'($urandom), 1'b0, '0);
        if (!sel_found)
            return;
        rec     = sel_rec;
        quantum = 1 << sel_level;
        elapsed = '0;
        repeat ($urandom_range(1, 3)) begin
            if (sel_level >= bottom_shadow)
                elapsed = elapsed + TIME_W'($urandom_range(0, 40));
            else
                elapsed = elapsed + TIME_W'($urandom_range(0, quantum));
            send_request(ACT_CHECK, rec, elapsed, 1'b0, '0);
        end
        progress = {1'b0, rec.done_time} + {1'b0, elapsed};
        if (progress >= {1'b0, rec.service_time} || $urandom_range(0, 9) == 0)
            return;
        rec.done_time = progress[TIME_W-1:0];
        send_request(ACT_REQUEUE, rec, TIME_W'($urandom), 1'b0, '0);
    endtask

    task automatic issue_random_traffic();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            // noise: any action, every field full range
            send_request(t_action'($urandom_range(0, 3)), random_process(1'b1),
                         TIME_W'($urandom), 1'b0, '0);
        end else if (roll < 12) begin
            // arrival burst, can run level 0 into overflow
            repeat ($urandom_range(14, 20))
                send_request(ACT_INSERT, random_process(1'b0), '0, 1'b0, '0);
        end else if (roll < 14) begin
            // preemption burst into one level
            repeat ($urandom_range(14, 20))
                send_request(ACT_REQUEUE, random_process(1'b0), '0, 1'b0, '0);
        end else if (roll < 42) begin
            send_request(ACT_INSERT, random_process($urandom_range(0, 7) == 0),
                         TIME_W'($urandom), 1'b0, '0);
        end else begin
            run_one_process();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        t_rec rec;
        int   phase_end;
        bit   paused;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = ACT_INSERT;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        check_bottom_level(BOTTOM_RST);

        foreach (directed_rows[i]) begin
            rec = '{directed_rows[i].dn, directed_rows[i].svc, directed_rows[i].pid};
            send_request(directed_rows[i].act, rec, directed_rows[i].el,
                         directed_rows[i].typed, directed_rows[i].want);
        end
        i_s_tvalid = 1'b0;
        wait_drained();

        // Queue contents carry over between phases, so a lowered bottom leaves
        // records in levels that are no longer used.
        for (int p = 0; p < PHASES; p++) begin
            write_bottom_level(PHASE_BOTTOM[p]);
            no_idle = (p == PHASES - 1);
            if (p == 1)
                hold_off_req = 1'b1;   // sender keeps going while results back up
            paused    = 1'b0;
            phase_end = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_end) begin
                issue_random_traffic();
                if (p == 2 && !paused && requests_sent > phase_end - PHASE_ITEMS / 2) begin
                    // sender pause until the block has delivered everything
                    paused     = 1'b1;
                    i_s_tvalid = 1'b0;
                    wait_drained();
                end
            end
            i_s_tvalid = 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("multilevel_feedback_scheduler_tb OK");
        else
            $display("multilevel_feedback_scheduler_tb NOT OK");
        $finish;
    end

endmodule
